// File: rtl/evp_pkg.sv
// ----------------------------------------------------------------------------
// evp_pkg
// Shared widths, codes and the per-configuration view coefficient bundle of
// the eye-view perspective projection block.
// ----------------------------------------------------------------------------
package evp_pkg;

	localparam int FRAC_BITS = 16;
	localparam int UNIT_BITS = 28;
	localparam int COORD_W   = 32;
	localparam int DIST_W    = 31;
	localparam int COEF_W    = UNIT_BITS + 2;
	localparam int RAD_W     = 32;
	localparam int VIEW_W    = 64;
	localparam int MAG_W     = 63;
	localparam int QUO_W     = 32;
	localparam int PRD_W     = COORD_W + COEF_W;
	localparam int PROD_W    = DIST_W + MAG_W;

	localparam logic [DIST_W-1:0] DIST_RESET = DIST_W'(1) << FRAC_BITS;

	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_ZERO_DEPTH = 2'd1;
	localparam logic [1:0] STAT_EYE_ORIGIN = 2'd2;
	localparam logic [1:0] STAT_SAT        = 2'd3;

	localparam logic [1:0] REG_EYE_X = 2'd0;
	localparam logic [1:0] REG_EYE_Y = 2'd1;
	localparam logic [1:0] REG_EYE_Z = 2'd2;
	localparam logic [1:0] REG_DIST  = 2'd3;

	// rows of the view matrix, already signed for a row-vector product
	typedef struct packed {
		logic signed [COEF_W-1:0] ax;
		logic signed [COEF_W-1:0] ay;
		logic signed [COEF_W-1:0] bx;
		logic signed [COEF_W-1:0] by;
		logic signed [COEF_W-1:0] bz;
		logic signed [COEF_W-1:0] cx;
		logic signed [COEF_W-1:0] cy;
		logic signed [COEF_W-1:0] cz;
		logic [RAD_W-1:0]         r;
		logic                     eye_origin;
		logic [DIST_W-1:0]        scr_dist;
	} view_cfg_t;

endpackage

// File: rtl/evp_proj_pipe.sv
// ----------------------------------------------------------------------------
// evp_proj_pipe
// Per-point pipeline: view transform, scaling by the screen distance and a
// one-bit-per-stage divide by the depth, then clamp and status.
// ----------------------------------------------------------------------------
module evp_proj_pipe
	import evp_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  view_cfg_t                 cfg,
	input  logic                      hold,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic signed [COORD_W-1:0] point_z,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [COORD_W-1:0] screen_x,
	output logic signed [COORD_W-1:0] screen_y,
	output logic [1:0]                status
);

	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic sat_x;
		logic sat_y;
		logic zero;
	} flag_t;

	function automatic logic [MAG_W+QUO_W-1:0] div_step(input logic [MAG_W-1:0] rem,
			input logic [QUO_W-1:0] nq, input logic [MAG_W-1:0] den);
		logic [MAG_W:0] sh;
		logic [MAG_W:0] df;
		sh = {rem, nq[QUO_W-1]};
		df = sh - {1'b0, den};
		if (sh >= {1'b0, den}) begin
			return {df[MAG_W-1:0], nq[QUO_W-2:0], 1'b1};
		end else begin
			return {sh[MAG_W-1:0], nq[QUO_W-2:0], 1'b0};
		end
	endfunction

	logic adv;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [PRD_W-1:0]  xa_s1, ya_s1, xb_s1, yb_s1, zb_s1, xc_s1, yc_s1, zc_s1;
	logic signed [VIEW_W-1:0] vx_s2, vy_s2, den_s2;
	logic [MAG_W-1:0]         mx_s3, my_s3, md_s3;
	flag_t                    fl_s3;
	logic [DIST_W+31:0]       lx_s4, ly_s4;
	logic [PROD_W-33:0]       hx_s4, hy_s4;
	logic [MAG_W-1:0]         md_s4;
	flag_t                    fl_s4;
	logic [PROD_W-1:0]        px_s5, py_s5;
	logic [MAG_W-1:0]         md_s5;
	flag_t                    fl_s5;

	// division stages, index 0 holds the initial remainder
	logic                     v_sd   [0:QUO_W];
	logic [MAG_W-1:0]         rx_sd  [0:QUO_W];
	logic [MAG_W-1:0]         ry_sd  [0:QUO_W];
	logic [QUO_W-1:0]         qx_sd  [0:QUO_W];
	logic [QUO_W-1:0]         qy_sd  [0:QUO_W];
	logic [MAG_W-1:0]         md_sd  [0:QUO_W];
	flag_t                    fl_sd  [0:QUO_W];

	logic                     out_valid_q;
	logic signed [COORD_W-1:0] screen_x_q, screen_y_q;
	logic [1:0]               status_q;

	logic signed [VIEW_W-1:0] rterm;
	logic [QUO_W-1:0]         lim_x, lim_y, mag_x, mag_y, fx, fy;
	logic                     sat_x, sat_y;
	logic [PROD_W-33:0]       hix, hiy;

	assign adv      = ~out_valid_q | ~out_stall;
	assign in_stall = hold | ~adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_sd[0] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid & ~hold;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_sd[0] <= v_s5;
			out_valid_q <= v_sd[QUO_W];
		end
	end

	assign rterm = $signed(VIEW_W'({cfg.r, {UNIT_BITS{1'b0}}}));

	assign hix = px_s5[PROD_W-1:32];
	assign hiy = py_s5[PROD_W-1:32];

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: point times view matrix rows
			xa_s1 <= point_x * cfg.ax;
			ya_s1 <= point_y * cfg.ay;
			xb_s1 <= point_x * cfg.bx;
			yb_s1 <= point_y * cfg.by;
			zb_s1 <= point_z * cfg.bz;
			xc_s1 <= point_x * cfg.cx;
			yc_s1 <= point_y * cfg.cy;
			zc_s1 <= point_z * cfg.cz;
			// s2: view coordinates, depth taken as -view z
			vx_s2  <= VIEW_W'(xa_s1) + VIEW_W'(ya_s1);
			vy_s2  <= VIEW_W'(xb_s1) + VIEW_W'(yb_s1) + VIEW_W'(zb_s1);
			den_s2 <= rterm - VIEW_W'(xc_s1) - VIEW_W'(yc_s1) - VIEW_W'(zc_s1);
			// s3: magnitudes and signs
			mx_s3 <= vx_s2[VIEW_W-1] ? MAG_W'(-vx_s2) : MAG_W'(vx_s2);
			my_s3 <= vy_s2[VIEW_W-1] ? MAG_W'(-vy_s2) : MAG_W'(vy_s2);
			md_s3 <= den_s2[VIEW_W-1] ? MAG_W'(-den_s2) : MAG_W'(den_s2);
			fl_s3.neg_x <= vx_s2[VIEW_W-1] ^ den_s2[VIEW_W-1];
			fl_s3.neg_y <= vy_s2[VIEW_W-1] ^ den_s2[VIEW_W-1];
			fl_s3.sat_x <= 1'b0;
			fl_s3.sat_y <= 1'b0;
			fl_s3.zero  <= (den_s2 == '0);
			// s4: distance times magnitude, split in halves
			lx_s4 <= cfg.scr_dist * mx_s3[31:0];
			ly_s4 <= cfg.scr_dist * my_s3[31:0];
			hx_s4 <= cfg.scr_dist * mx_s3[MAG_W-1:32];
			hy_s4 <= cfg.scr_dist * my_s3[MAG_W-1:32];
			md_s4 <= md_s3;
			fl_s4 <= fl_s3;
			// s5: full product
			px_s5 <= PROD_W'(lx_s4) + {hx_s4, 32'd0};
			py_s5 <= PROD_W'(ly_s4) + {hy_s4, 32'd0};
			md_s5 <= md_s4;
			fl_s5 <= fl_s4;
			// quotient of 2^32 or more saturates at once
			rx_sd[0] <= MAG_W'(hix);
			ry_sd[0] <= MAG_W'(hiy);
			qx_sd[0] <= px_s5[31:0];
			qy_sd[0] <= py_s5[31:0];
			md_sd[0] <= md_s5;
			fl_sd[0] <= '{neg_x: fl_s5.neg_x, neg_y: fl_s5.neg_y,
				sat_x: (MAG_W'(hix) >= md_s5), sat_y: (MAG_W'(hiy) >= md_s5),
				zero: fl_s5.zero};
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k+1] <= 1'b0;
			end else if (adv) begin
				v_sd[k+1] <= v_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				{rx_sd[k+1], qx_sd[k+1]} <= div_step(rx_sd[k], qx_sd[k], md_sd[k]);
				{ry_sd[k+1], qy_sd[k+1]} <= div_step(ry_sd[k], qy_sd[k], md_sd[k]);
				md_sd[k+1] <= md_sd[k];
				fl_sd[k+1] <= fl_sd[k];
			end
		end
	end

	// clamp and sign
	always_comb begin
		lim_x = fl_sd[QUO_W].neg_x ? 32'h8000_0000 : 32'h7FFF_FFFF;
		lim_y = fl_sd[QUO_W].neg_y ? 32'h8000_0000 : 32'h7FFF_FFFF;
		sat_x = fl_sd[QUO_W].sat_x | (qx_sd[QUO_W] > lim_x);
		sat_y = fl_sd[QUO_W].sat_y | (qy_sd[QUO_W] > lim_y);
		mag_x = sat_x ? lim_x : qx_sd[QUO_W];
		mag_y = sat_y ? lim_y : qy_sd[QUO_W];
		fx = fl_sd[QUO_W].neg_x ? -mag_x : mag_x;
		fy = fl_sd[QUO_W].neg_y ? -mag_y : mag_y;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			priority if (cfg.eye_origin) begin
				screen_x_q <= '0;
				screen_y_q <= '0;
				status_q   <= STAT_EYE_ORIGIN;
			end else if (fl_sd[QUO_W].zero) begin
				screen_x_q <= '0;
				screen_y_q <= '0;
				status_q   <= STAT_ZERO_DEPTH;
			end else begin
				screen_x_q <= $signed(fx);
				screen_y_q <= $signed(fy);
				status_q   <= (sat_x | sat_y) ? STAT_SAT : STAT_OK;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign screen_x  = screen_x_q;
	assign screen_y  = screen_y_q;
	assign status    = status_q;

endmodule

// File: rtl/eye_view_perspective_projection.sv
// throughput: one item per cycle while in_stall is low; the per-point divide is a 32-stage pipeline
// after reset and after every register write the view coefficients are rebuilt
// by a shared multiply / square-root / divide unit, with in_stall high
// reset: eye at origin, screen distance 1.0, pipeline empty
// ----------------------------------------------------------------------------
// eye_view_perspective_projection
// Look-at view transform with perspective projection of one point per item.
// ----------------------------------------------------------------------------
module eye_view_perspective_projection
	import evp_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [3:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic signed [COORD_W-1:0] point_z,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [COORD_W-1:0] screen_x,
	output logic signed [COORD_W-1:0] screen_y,
	output logic [1:0]                status
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQ   = 3'd1;
	localparam logic [2:0] ST_SQRT = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;

	localparam logic [5:0] SQ_LAST   = 6'd2;
	localparam logic [5:0] SQRT_LAST = 6'd31;
	localparam logic [5:0] DIV_LAST  = 6'(UNIT_BITS + 31);
	localparam int         NUM_W     = UNIT_BITS + 32;

	localparam logic [COEF_W-1:0] UNIT_ONE = COEF_W'(1) << UNIT_BITS;
	localparam logic signed [59:0] RND     = (60'd1 << UNIT_BITS) - 60'd1;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	logic signed [31:0] eye_x_q, eye_y_q, eye_z_q;
	logic [DIST_W-1:0]  dist_q;
	logic               wr;

	logic [2:0] state_q;
	logic [5:0] cnt_q;
	logic [1:0] run_q;

	logic [63:0] rho2_q, r2_q;
	logic [31:0] rho_q, r_q;

	logic [63:0] sq_op_q;
	logic [34:0] sq_rem_q;
	logic [31:0] sq_root_q;

	logic [NUM_W-1:0] dv_num_q;
	logic [31:0]      dv_rem_q, dv_den_q;
	logic             dv_neg_q;

	logic signed [COEF_W-1:0] ct_q, st_q, cp_q, sp_q, ctcp_q, stcp_q, ctsp_q, stsp_q;

	logic [31:0] sq_mag;
	logic [63:0] sq_prod;
	logic [34:0] sq_sh, sq_trial, sq_rem_nx;
	logic        sq_ge;
	logic [31:0] sq_root_nx;

	logic [32:0]       dv_sh;
	logic              dv_ge;
	logic [31:0]       dv_rem_nx;
	logic [NUM_W-1:0]  dv_num_nx;
	logic [COEF_W-1:0] dv_qz, dv_ratio;
	logic [1:0]        nr;
	logic [31:0]       src_num, src_den;
	logic              src_neg;

	logic signed [COEF_W-1:0] mul_a, mul_b;
	logic signed [59:0]       mul_p, mul_adj;
	logic signed [COEF_W-1:0] mul_r;

	view_cfg_t cfg;

	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_x_q <= '0;
			eye_y_q <= '0;
			eye_z_q <= '0;
			dist_q  <= DIST_RESET;
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_EYE_X: eye_x_q <= $signed(pwdata);
				REG_EYE_Y: eye_y_q <= $signed(pwdata);
				REG_EYE_Z: eye_z_q <= $signed(pwdata);
				REG_DIST:  dist_q  <= pwdata[DIST_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_EYE_X: prdata = eye_x_q;
			REG_EYE_Y: prdata = eye_y_q;
			REG_EYE_Z: prdata = eye_z_q;
			REG_DIST:  prdata = {1'b0, dist_q};
		endcase
	end

	// squares of the eye coordinates
	always_comb begin
		unique case (cnt_q[1:0])
			2'd0:    sq_mag = mag32(eye_x_q);
			2'd1:    sq_mag = mag32(eye_y_q);
			default: sq_mag = mag32(eye_z_q);
		endcase
		sq_prod = 64'(sq_mag) * 64'(sq_mag);
	end

	// one root bit per cycle
	always_comb begin
		sq_sh      = {sq_rem_q[32:0], sq_op_q[63:62]};
		sq_trial   = {1'b0, sq_root_q, 2'b01};
		sq_ge      = sq_sh >= sq_trial;
		sq_rem_nx  = sq_ge ? sq_sh - sq_trial : sq_sh;
		sq_root_nx = {sq_root_q[30:0], sq_ge};
	end

	// one quotient bit per cycle
	always_comb begin
		dv_sh     = {dv_rem_q, dv_num_q[NUM_W-1]};
		dv_ge     = dv_sh >= {1'b0, dv_den_q};
		dv_rem_nx = dv_ge ? 32'(dv_sh - {1'b0, dv_den_q}) : dv_sh[31:0];
		dv_num_nx = {dv_num_q[NUM_W-2:0], dv_ge};
		dv_qz     = COEF_W'(dv_num_nx[UNIT_BITS:0]);
		dv_ratio  = dv_neg_q ? -dv_qz : dv_qz;
	end

	// operands of the next ratio: cos/sin theta over rho, cos/sin phi over r
	always_comb begin
		nr = (state_q == ST_DIV) ? run_q + 2'd1 : 2'd0;
		unique case (nr)
			2'd0: begin
				src_num = mag32(eye_x_q);
				src_den = rho_q;
				src_neg = eye_x_q[31];
			end
			2'd1: begin
				src_num = mag32(eye_y_q);
				src_den = rho_q;
				src_neg = eye_y_q[31];
			end
			2'd2: begin
				src_num = mag32(eye_z_q);
				src_den = r_q;
				src_neg = eye_z_q[31];
			end
			default: begin
				src_num = rho_q;
				src_den = r_q;
				src_neg = 1'b0;
			end
		endcase
	end

	// ratio products, truncated toward zero
	always_comb begin
		unique case (run_q)
			2'd0: begin mul_a = ct_q; mul_b = cp_q; end
			2'd1: begin mul_a = st_q; mul_b = cp_q; end
			2'd2: begin mul_a = ct_q; mul_b = sp_q; end
			default: begin mul_a = st_q; mul_b = sp_q; end
		endcase
		mul_p   = mul_a * mul_b;
		mul_adj = mul_p + (mul_p[59] ? RND : 60'sd0);
		mul_r   = COEF_W'(mul_adj >>> UNIT_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SQ;
			cnt_q   <= '0;
			run_q   <= '0;
		end else if (wr) begin
			state_q <= ST_SQ;
			cnt_q   <= '0;
			run_q   <= '0;
		end else begin
			unique case (state_q)
				ST_SQ: begin
					cnt_q <= (cnt_q == SQ_LAST) ? 6'd0 : cnt_q + 6'd1;
					if (cnt_q == SQ_LAST) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					cnt_q <= (cnt_q == SQRT_LAST) ? 6'd0 : cnt_q + 6'd1;
					if (cnt_q == SQRT_LAST) begin
						run_q <= run_q + 2'd1;
						if (run_q == 2'd1) begin
							state_q <= ST_DIV;
							run_q   <= '0;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= (cnt_q == DIV_LAST) ? 6'd0 : cnt_q + 6'd1;
					if (cnt_q == DIV_LAST) begin
						run_q <= run_q + 2'd1;
						if (run_q == 2'd3) begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					run_q <= run_q + 2'd1;
					if (run_q == 2'd3) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_SQ: begin
				priority case (cnt_q)
					6'd0:    rho2_q <= sq_prod;
					6'd1:    rho2_q <= rho2_q + sq_prod;
					default: begin
						r2_q      <= rho2_q + sq_prod;
						sq_op_q   <= rho2_q;
						sq_rem_q  <= '0;
						sq_root_q <= '0;
					end
				endcase
			end
			ST_SQRT: begin
				sq_op_q   <= {sq_op_q[61:0], 2'b00};
				sq_rem_q  <= sq_rem_nx;
				sq_root_q <= sq_root_nx;
				if (cnt_q == SQRT_LAST) begin
					sq_rem_q  <= '0;
					sq_root_q <= '0;
					if (run_q == 2'd0) begin
						rho_q   <= sq_root_nx;
						sq_op_q <= r2_q;
					end else begin
						r_q      <= sq_root_nx;
						dv_num_q <= {src_num, {UNIT_BITS{1'b0}}};
						dv_den_q <= src_den;
						dv_neg_q <= src_neg;
						dv_rem_q <= '0;
					end
				end
			end
			ST_DIV: begin
				dv_num_q <= dv_num_nx;
				dv_rem_q <= dv_rem_nx;
				if (cnt_q == DIV_LAST) begin
					// eye on the z axis: theta taken as zero
					unique case (run_q)
						2'd0:    ct_q <= (rho_q == '0) ? UNIT_ONE : dv_ratio;
						2'd1:    st_q <= (rho_q == '0) ? '0 : dv_ratio;
						2'd2:    cp_q <= dv_ratio;
						default: sp_q <= dv_ratio;
					endcase
					dv_num_q <= {src_num, {UNIT_BITS{1'b0}}};
					dv_den_q <= src_den;
					dv_neg_q <= src_neg;
					dv_rem_q <= '0;
				end
			end
			ST_MUL: begin
				unique case (run_q)
					2'd0:    ctcp_q <= mul_r;
					2'd1:    stcp_q <= mul_r;
					2'd2:    ctsp_q <= mul_r;
					default: stsp_q <= mul_r;
				endcase
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cfg.ax         = -st_q;
		cfg.ay         = ct_q;
		cfg.bx         = -ctcp_q;
		cfg.by         = -stcp_q;
		cfg.bz         = sp_q;
		cfg.cx         = ctsp_q;
		cfg.cy         = stsp_q;
		cfg.cz         = cp_q;
		cfg.r          = r_q;
		cfg.eye_origin = (r_q == '0);
		cfg.scr_dist   = dist_q;
	end

	evp_proj_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.hold      (state_q != ST_IDLE),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.screen_x  (screen_x),
		.screen_y  (screen_y),
		.status    (status)
	);

endmodule
